@@ rtl/mbd_pkg.sv @@
// mbd_pkg: shared types and constants of the memory bank decoder
// target codes, register indexes, address window limits and reset values
// no dependencies
package mbd_pkg;

	// backing target of one access
	typedef enum logic [2:0] {
		TGT_NONE  = 3'd0,
		TGT_MAIN  = 3'd1,
		TGT_EXT   = 3'd2,
		TGT_BASIC = 3'd3,
		TGT_ROMB  = 3'd4,
		TGT_ROMA  = 3'd5,
		TGT_ROMC  = 3'd6
	} target_t;

	// configuration register indexes
	localparam int unsigned CfgIdxW = 3;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_BANK_A     = 3'd0;
	localparam cfg_idx_t REG_BANK_B     = 3'd1;
	localparam cfg_idx_t REG_ROM_PRES   = 3'd2;
	localparam cfg_idx_t REG_EXT_PRES   = 3'd3;
	localparam cfg_idx_t REG_FLOPPY_KND = 3'd4;
	localparam cfg_idx_t REG_FLOPPY_EN  = 3'd5;

	localparam int unsigned CfgDataW = 8;

	// floppy drive kinds
	typedef logic [1:0] floppy_kind_t;
	localparam floppy_kind_t FLOPPY_525 = 2'd1;
	localparam floppy_kind_t FLOPPY_8IN = 2'd2;

	// register masks and reset values
	localparam logic [7:0] BankAMask  = 8'hce;
	localparam logic [7:0] BankAReset = 8'h0e;
	localparam logic [7:0] ExtRdAll   = 8'h50;

	// address windows
	localparam logic [15:0] AddrVidLo   = 16'h0400;
	localparam logic [15:0] AddrVidHi   = 16'h43ff;
	localparam logic [15:0] AddrHigh    = 16'h8000;
	localparam logic [15:0] AddrBasicLo = 16'ha000;
	localparam logic [15:0] AddrC000    = 16'hc000;
	localparam logic [15:0] AddrE000    = 16'he000;
	localparam logic [15:0] AddrF000    = 16'hf000;
	localparam logic [15:0] AddrFlopLo  = 16'hf800;
	localparam logic [15:0] AddrIoLo    = 16'hff00;
	localparam logic [15:0] AddrIoHi    = 16'hffef;
	localparam logic [15:0] AddrTopLo   = 16'hfff0;

endpackage

@@ rtl/mbd_req_if.sv @@
// mbd_req_if: access request channel (opcode and address per beat)
// depends on nothing but plain logic types
interface mbd_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] address;

	modport source (output valid, output opcode, output address, input ready);
	modport sink (input valid, input opcode, input address, output ready);
endinterface

@@ rtl/mbd_rsp_if.sv @@
// mbd_rsp_if: decode result channel (target, offset and flags per beat)
// depends on mbd_pkg for the target type
interface mbd_rsp_if;
	logic            valid;
	logic            ready;
	mbd_pkg::target_t target;
	logic [15:0]     offset;
	logic            io_hit;
	logic            video_on_main;

	modport source (output valid, output target, output offset, output io_hit,
		output video_on_main, input ready);
	modport sink (input valid, input target, input offset, input io_hit,
		input video_on_main, output ready);
endinterface

@@ rtl/memory_bank_decoder_unit.sv @@
// memory_bank_decoder_unit: top level of the memory bank decoder
// depends on mbd_pkg, mbd_req_if and mbd_rsp_if
//
// channel  | dir | beat contents
// ---------+-----+---------------------------------------------
// req      | in  | opcode (0 read, 1 write), address[15:0]
// rsp      | out | target[2:0], offset[15:0], io_hit, video_on_main
// cfg      | in  | cfg_we, cfg_index[2:0], cfg_data[7:0] (write only)
//
// one beat per cycle while rsp.ready stays high; a beat passes through the request
// register and the result register with the decode logic between them
// arst_n clears both valid flags and loads the register reset values
// rsp.ready low holds the result; req is still taken while the request
// register is empty or moving on, so a stall stops input only once full
module memory_bank_decoder_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  mbd_pkg::cfg_idx_t                      cfg_index,
	input  logic [mbd_pkg::CfgDataW-1:0]           cfg_data,
	mbd_req_if.sink                                req,
	mbd_rsp_if.source                              rsp
);

	// configuration registers
	logic [7:0] bank_a_q;
	logic [7:0] bank_b_q;
	logic [3:0] rom_pres_q;
	logic       ext_pres_q;
	logic [1:0] floppy_kind_q;
	logic [1:0] floppy_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_a_q      <= mbd_pkg::BankAReset;
			bank_b_q      <= '0;
			rom_pres_q    <= '0;
			ext_pres_q    <= 1'b0;
			floppy_kind_q <= '0;
			floppy_en_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mbd_pkg::REG_BANK_A:     bank_a_q      <= cfg_data & mbd_pkg::BankAMask;
				mbd_pkg::REG_BANK_B:     bank_b_q      <= cfg_data;
				mbd_pkg::REG_ROM_PRES:   rom_pres_q    <= cfg_data[3:0];
				mbd_pkg::REG_EXT_PRES:   ext_pres_q    <= cfg_data[0];
				mbd_pkg::REG_FLOPPY_KND: floppy_kind_q <= cfg_data[1:0];
				mbd_pkg::REG_FLOPPY_EN:  floppy_en_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic        valid_s1;
	logic        opcode_s1;
	logic [15:0] addr_s1;
	logic        out_valid_q;
	logic        out_free;
	logic        adv_s1;

	assign out_free  = !out_valid_q || rsp.ready;
	assign adv_s1    = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			opcode_s1 <= req.opcode;
			addr_s1   <= req.address;
		end
	end

	// window decode
	logic             in_io;
	logic             in_vid;
	logic             sel_ext;
	mbd_pkg::target_t ext_tgt;
	mbd_pkg::target_t basic_tgt;
	mbd_pkg::target_t flop_tgt;
	mbd_pkg::target_t wr_tgt;
	mbd_pkg::target_t rd_tgt;
	mbd_pkg::target_t tgt;
	logic [15:0]      offset;

	assign in_io   = (addr_s1 >= mbd_pkg::AddrIoLo) && (addr_s1 <= mbd_pkg::AddrIoHi);
	assign in_vid  = (addr_s1 >= mbd_pkg::AddrVidLo) && (addr_s1 <= mbd_pkg::AddrVidHi);
	assign sel_ext = (bank_b_q[3:2] == 2'b01) || (bank_b_q[3:2] == 2'b10);
	assign ext_tgt   = ext_pres_q ? mbd_pkg::TGT_EXT : mbd_pkg::TGT_NONE;
	assign basic_tgt = rom_pres_q[0] ? mbd_pkg::TGT_BASIC : mbd_pkg::TGT_NONE;

	// floppy rom choice, the 5/8-inch port overrides the 3-inch one
	always_comb begin
		flop_tgt = mbd_pkg::TGT_NONE;
		if (floppy_en_q[0] && rom_pres_q[2]) begin
			flop_tgt = mbd_pkg::TGT_ROMB;
		end
		if (floppy_en_q[1]) begin
			if (floppy_kind_q == mbd_pkg::FLOPPY_525) begin
				if (rom_pres_q[1]) flop_tgt = mbd_pkg::TGT_ROMA;
				else if (rom_pres_q[3]) flop_tgt = mbd_pkg::TGT_ROMC;
			end else if (floppy_kind_q == mbd_pkg::FLOPPY_8IN) begin
				if (rom_pres_q[3]) flop_tgt = mbd_pkg::TGT_ROMC;
				else if (rom_pres_q[1]) flop_tgt = mbd_pkg::TGT_ROMA;
			end
		end
	end

	// write target
	always_comb begin
		if (in_io) begin
			wr_tgt = mbd_pkg::TGT_MAIN;
		end else if (in_vid) begin
			wr_tgt = sel_ext ? ext_tgt : mbd_pkg::TGT_MAIN;
		end else if (addr_s1 < mbd_pkg::AddrHigh) begin
			wr_tgt = bank_b_q[3] ? ext_tgt : mbd_pkg::TGT_MAIN;
		end else begin
			wr_tgt = bank_b_q[4] ? ext_tgt : mbd_pkg::TGT_MAIN;
		end
	end

	// read target
	always_comb begin
		if (in_io) begin
			rd_tgt = mbd_pkg::TGT_NONE;
		end else if (in_vid) begin
			rd_tgt = (sel_ext && bank_b_q[5]) ? ext_tgt : mbd_pkg::TGT_MAIN;
		end else if (addr_s1 < mbd_pkg::AddrHigh) begin
			rd_tgt = (bank_b_q[3] && bank_b_q[5]) ? ext_tgt : mbd_pkg::TGT_MAIN;
		end else if ((bank_b_q & mbd_pkg::ExtRdAll) == mbd_pkg::ExtRdAll) begin
			rd_tgt = ext_tgt;
		end else if (addr_s1 < mbd_pkg::AddrBasicLo) begin
			rd_tgt = mbd_pkg::TGT_MAIN;
		end else if (addr_s1 < mbd_pkg::AddrC000) begin
			rd_tgt = (!bank_a_q[1] && bank_a_q[6]) ? mbd_pkg::TGT_MAIN : basic_tgt;
		end else if (addr_s1 < mbd_pkg::AddrE000) begin
			rd_tgt = (!bank_a_q[2] && bank_a_q[7]) ? mbd_pkg::TGT_MAIN : basic_tgt;
		end else if (addr_s1 < mbd_pkg::AddrF000) begin
			rd_tgt = (!bank_a_q[3] && bank_a_q[7]) ? mbd_pkg::TGT_MAIN : basic_tgt;
		end else if (addr_s1 >= mbd_pkg::AddrTopLo) begin
			rd_tgt = bank_b_q[1] ? mbd_pkg::TGT_MAIN : basic_tgt;
		end else if (bank_b_q[0]) begin
			rd_tgt = mbd_pkg::TGT_MAIN;
		end else if ((addr_s1 >= mbd_pkg::AddrFlopLo) &&
			(flop_tgt != mbd_pkg::TGT_NONE)) begin
			rd_tgt = flop_tgt;
		end else begin
			rd_tgt = basic_tgt;
		end
	end

	// target and offset inside it
	always_comb begin
		tgt = opcode_s1 ? wr_tgt : rd_tgt;
		case (tgt)
			mbd_pkg::TGT_MAIN,
			mbd_pkg::TGT_EXT:   offset = addr_s1;
			mbd_pkg::TGT_BASIC: offset = addr_s1 - mbd_pkg::AddrBasicLo;
			mbd_pkg::TGT_ROMA,
			mbd_pkg::TGT_ROMB,
			mbd_pkg::TGT_ROMC:  offset = addr_s1 - mbd_pkg::AddrFlopLo;
			default:            offset = '0;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp.target        <= tgt;
			rsp.offset        <= offset;
			rsp.io_hit        <= in_io;
			rsp.video_on_main <= !sel_ext;
		end
	end

	assign rsp.valid = out_valid_q;

	// checks
	a_none_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.target == mbd_pkg::TGT_NONE) |-> (rsp.offset == 16'h0000))
		else $error("no-target beat with non-zero offset");

	a_io_target: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.io_hit) |->
		(rsp.target == mbd_pkg::TGT_MAIN || rsp.target == mbd_pkg::TGT_NONE))
		else $error("i/o window beat mapped beyond main ram");

	a_floppy_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.target == mbd_pkg::TGT_ROMA || rsp.target == mbd_pkg::TGT_ROMB ||
		rsp.target == mbd_pkg::TGT_ROMC)) |-> (rsp.offset < 16'h0700))
		else $error("floppy rom offset beyond f800..feff");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(addr_s1)))
		else $error("request register lost a beat under stall");

endmodule
